// ===== hw/rtl/ptc_pkg.sv =====
// shared types and constants for the playback transport controller
`default_nettype none
package ptc_pkg;

  localparam int KeyDepthDefault  = 1024;
  localparam int FrameBitsDefault = 24;

  localparam logic [7:0] BtnLeft  = 8'h04;
  localparam logic [7:0] BtnRight = 8'h08;
  localparam logic [7:0] BtnA     = 8'h10;
  localparam logic [7:0] BtnB     = 8'h20;
  localparam logic [7:0] BtnC     = 8'h40;
  localparam logic [7:0] BtnD     = 8'h80;

  typedef enum logic [1:0] {
    TM_PLAY    = 2'd0,
    TM_PAUSE   = 2'd1,
    TM_FORWARD = 2'd2,
    TM_REWIND  = 2'd3
  } tmode_t;

  typedef enum logic [1:0] {
    AUD_NONE    = 2'd0,
    AUD_RESTART = 2'd1,
    AUD_HALT    = 2'd2
  } audio_t;

  localparam logic [2:0] CfgFrameCount = 3'd0;
  localparam logic [2:0] CfgKeyCount   = 3'd1;
  localparam logic [2:0] CfgSeekFrames = 3'd2;
  localparam logic [2:0] CfgRewPeriod  = 3'd3;
  localparam logic [2:0] CfgOverlay    = 3'd4;
  localparam logic [2:0] CfgSpeedLow   = 3'd5;
  localparam logic [2:0] CfgSpeedMid   = 3'd6;
  localparam logic [2:0] CfgSpeedHigh  = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_BTN, ST_SEEK_INIT, ST_SEEK_RD, ST_SEEK_WAIT, ST_SEEK_CMP,
    ST_SEEK_LAST, ST_SEEK_LAND, ST_MOVE, ST_STEP, ST_FINISH, ST_OUT
  } state_t;

  // seek purpose: which button or rewind started the lookup
  typedef enum logic [1:0] {
    SK_C   = 2'd0,
    SK_D   = 2'd1,
    SK_REW = 2'd2
  } seek_t;

  // controller to datapath
  typedef struct packed {
    logic  capture;    // latch input beat, clear tick results
    logic  load_wr;    // write table entry
    logic  buttons;    // apply button rules except seeks
    logic  seek_init;  // compute target, open search window
    seek_t seek_kind;
    logic  rd_mid;     // issue table read at mid
    logic  rd_lo;      // issue table read at lo
    logic  cmp;        // narrow window with read data
    logic  land;       // apply landing
    logic  move;       // rewind countdown or prepare steps
    logic  step;       // advance one frame
    logic  finish;     // overlay and output latch
  } ptc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic need_c;
    logic need_d;
    logic search_done;
    logic rew_jump;
    logic steps_left;
  } ptc_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ptc_ctrl.sv =====
// sequencer for load and tick beats
`default_nettype none
module ptc_ctrl
  import ptc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire ptc_sts_t sts,
  output ptc_cmd_t      cmd
);

  state_t state, state_next;
  seek_t  kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      kind  <= SK_C;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    cmd        = '0;
    cmd.seek_kind = kind;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts.is_tick) begin
          state_next = ST_BTN;
        end else begin
          cmd.load_wr = 1'b1;
          cmd.finish  = 1'b1;
          state_next  = ST_OUT;
        end
      end
      ST_BTN: begin
        cmd.buttons = 1'b1;
        state_next  = ST_SEEK_INIT;
        kind_next   = SK_C;
      end
      ST_SEEK_INIT: begin
        if (kind == SK_C && sts.need_c) begin
          cmd.seek_init = 1'b1;
          state_next    = ST_SEEK_RD;
        end else if ((kind == SK_C || kind == SK_D) && sts.need_d) begin
          kind_next      = SK_D;
          cmd.seek_kind  = SK_D;
          cmd.seek_init  = 1'b1;
          state_next     = ST_SEEK_RD;
        end else begin
          state_next = ST_MOVE;
        end
      end
      ST_SEEK_RD: begin
        if (sts.search_done) begin
          cmd.rd_lo  = 1'b1;
          state_next = ST_SEEK_LAST;
        end else begin
          cmd.rd_mid = 1'b1;
          state_next = ST_SEEK_WAIT;
        end
      end
      ST_SEEK_WAIT: state_next = ST_SEEK_CMP;
      ST_SEEK_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = ST_SEEK_RD;
      end
      ST_SEEK_LAST: state_next = ST_SEEK_LAND;
      ST_SEEK_LAND: begin
        cmd.land = 1'b1;
        if (kind == SK_C && sts.need_d) begin
          kind_next  = SK_D;
          state_next = ST_SEEK_INIT;
        end else if (kind == SK_REW) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_MOVE;
        end
      end
      ST_MOVE: begin
        cmd.move = 1'b1;
        if (sts.rew_jump) begin
          kind_next     = SK_REW;
          cmd.seek_kind = SK_REW;
          cmd.seek_init = 1'b1;
          state_next    = ST_SEEK_RD;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (sts.steps_left) cmd.step = 1'b1;
        else state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ptc_dp.sv =====
// registers, keyframe memory and arithmetic of the transport controller
`default_nettype none
module ptc_dp
  import ptc_pkg::*;
#(
  parameter int KEY_DEPTH  = KeyDepthDefault,
  parameter int FRAME_BITS = FrameBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ptc_cmd_t    cmd,
  output ptc_sts_t         sts,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        mode,
  input  wire logic [9:0]  key_slot,
  input  wire logic [23:0] key_value,
  input  wire logic [7:0]  pad_bits,
  input  wire logic        start_held,
  output logic [1:0]       transport_mode,
  output logic [3:0]       speed_now,
  output logic [23:0]      position,
  output logic [23:0]      shown_first,
  output logic [4:0]       shown_count,
  output logic             palette_reload,
  output logic [1:0]       audio_action,
  output logic [23:0]      audio_frame,
  output logic             overlay_on
);

  localparam int AW = $clog2(KEY_DEPTH);
  localparam int CW = AW + 1;
  localparam int FB = FRAME_BITS;
  localparam logic [FB-1:0] ONE_F = FB'(1);

  // configuration
  logic [23:0] frame_count;
  logic [10:0] keyframe_count;
  logic [15:0] seek_frames;
  logic [7:0]  rewind_period;
  logic [9:0]  overlay_hold;
  logic [3:0]  speed_low, speed_mid, speed_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= 24'd2; keyframe_count <= 11'd1; seek_frames <= 16'd600;
      rewind_period <= 8'd6; overlay_hold <= 10'd180;
      speed_low <= 4'd2; speed_mid <= 4'd5; speed_high <= 4'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgFrameCount: frame_count    <= cfg_data;
        CfgKeyCount:   keyframe_count <= cfg_data[10:0];
        CfgSeekFrames: seek_frames    <= cfg_data[15:0];
        CfgRewPeriod:  rewind_period  <= cfg_data[7:0];
        CfgOverlay:    overlay_hold   <= cfg_data[9:0];
        CfgSpeedLow:   speed_low      <= cfg_data[3:0];
        CfgSpeedMid:   speed_mid      <= cfg_data[3:0];
        CfgSpeedHigh:  speed_high     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // captured beat
  logic        b_tick;
  logic [9:0]  b_slot;
  logic [23:0] b_value;
  logic [7:0]  pressed;
  logic        st_pressed;

  // transport state
  tmode_t      mode_reg;
  logic [1:0]  speed_level;
  logic [3:0]  speed_reg;
  logic [FB-1:0] frame_pos;
  logic [7:0]  rewind_count;
  logic [9:0]  overlay_count;
  logic [7:0]  last_pad;
  logic        last_start;
  logic        audio_live;

  // tick results
  logic [FB-1:0] t_first;
  logic [4:0]    t_count;
  logic          t_palette;
  audio_t        t_act;
  logic [FB-1:0] t_at;
  logic [3:0]    steps;

  // search window
  logic [CW-1:0] lo, hi;
  logic [FB-1:0] target;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] mid;
  logic [FB-1:0] fc;

  // keyframe memory
  logic [FB-1:0] kf_mem [KEY_DEPTH];
  logic [FB-1:0] rd_data;
  logic [AW-1:0] rd_addr;

  assign mid = CW'((CW+1)'(lo) + (CW+1)'(hi) >> 1);
  assign rd_addr = cmd.rd_lo ? lo[AW-1:0] : mid[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_wr && 32'(b_slot) < KEY_DEPTH) kf_mem[AW'(b_slot)] <= FB'(b_value);
    if (cmd.rd_mid || cmd.rd_lo) rd_data <= kf_mem[rd_addr];
  end

  always_comb begin
    if (keyframe_count == 11'd0) n_eff = CW'(1);
    else if (32'(keyframe_count) > KEY_DEPTH) n_eff = CW'(KEY_DEPTH);
    else n_eff = CW'(keyframe_count);
    fc = (frame_count == 24'd0) ? ONE_F : FB'(frame_count);
  end

  // seek target, clamped to the last frame
  logic [FB:0]   fwd_sum;
  logic [FB-1:0] tgt_cd;
  always_comb begin
    fwd_sum = {1'b0, frame_pos} + (FB+1)'(seek_frames);
    if (cmd.seek_kind == SK_C)
      tgt_cd = (frame_pos > FB'(seek_frames)) ? frame_pos - FB'(seek_frames) : '0;
    else
      tgt_cd = (fwd_sum >= {1'b0, fc}) ? fc - ONE_F : fwd_sum[FB-1:0];
    if (cmd.seek_kind == SK_C && tgt_cd >= fc) tgt_cd = fc - ONE_F;
  end

  assign sts.is_tick     = b_tick;
  assign sts.need_c      = (pressed & BtnC) != 8'd0;
  assign sts.need_d      = (pressed & BtnD) != 8'd0;
  assign sts.search_done = (CW+1)'(lo) + 1'b1 >= (CW+1)'(hi);
  assign sts.rew_jump    = (mode_reg == TM_REWIND) && (rewind_count == 8'd1)
                           && (frame_pos != '0);
  assign sts.steps_left  = steps != 4'd0;

  logic [FB-1:0] pos_inc;
  assign pos_inc = frame_pos + ONE_F;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= TM_PLAY; speed_level <= 2'd0; speed_reg <= 4'd1;
      frame_pos <= ONE_F; rewind_count <= 8'd6; overlay_count <= 10'd180;
      last_pad <= 8'd0; last_start <= 1'b0; audio_live <= 1'b1;
      b_tick <= 1'b0;
    end else begin
      if (cmd.capture) begin
        b_tick  <= mode;
        b_slot  <= key_slot;
        b_value <= key_value;
        pressed <= pad_bits & ~last_pad;
        st_pressed <= start_held & ~last_start;
        if (mode) begin
          last_pad   <= pad_bits;
          last_start <= start_held;
        end
        t_first <= '0; t_count <= 5'd0; t_palette <= 1'b0;
        t_act <= AUD_NONE; t_at <= '0; steps <= 4'd0;
      end

      if (cmd.buttons) begin : btn
        tmode_t m;
        logic [1:0] lvl;
        logic [3:0] spd;
        logic live;
        audio_t act;
        logic [FB-1:0] at;
        m = mode_reg; lvl = speed_level; spd = speed_reg; live = audio_live;
        act = AUD_NONE; at = '0;
        if (pressed != 8'd0 || st_pressed) overlay_count <= overlay_hold;
        if ((pressed & BtnA) != 8'd0 || st_pressed) begin
          m = (m == TM_PAUSE) ? TM_PLAY : TM_PAUSE;
          spd = 4'd1;
          if (m == TM_PAUSE) begin
            if (live) begin act = AUD_HALT; at = '0; live = 1'b0; end
          end else begin
            act = AUD_RESTART; at = frame_pos; live = 1'b1;
          end
        end
        if ((pressed & BtnB) != 8'd0) begin
          m = TM_PLAY; spd = 4'd1;
          act = AUD_RESTART; at = frame_pos; live = 1'b1;
        end
        if ((pressed & BtnRight) != 8'd0) begin
          if (m != TM_FORWARD) lvl = 2'd0;
          else if (lvl < 2'd2) lvl = lvl + 2'd1;
          m = TM_FORWARD;
          spd = (lvl == 2'd0) ? speed_low : (lvl == 2'd1) ? speed_mid : speed_high;
          if (live) begin act = AUD_HALT; at = '0; live = 1'b0; end
        end
        if ((pressed & BtnLeft) != 8'd0) begin
          m = TM_REWIND; spd = 4'd1;
          rewind_count <= rewind_period;
          if (live) begin act = AUD_HALT; at = '0; live = 1'b0; end
        end
        mode_reg <= m; speed_level <= lvl; speed_reg <= spd; audio_live <= live;
        t_act <= act; t_at <= at;
      end

      if (cmd.seek_init) begin
        lo <= '0;
        hi <= n_eff;
        if (cmd.seek_kind == SK_REW) target <= frame_pos - ONE_F;
        else target <= tgt_cd;
      end

      if (cmd.cmp) begin
        if (rd_data <= target) lo <= mid;
        else hi <= mid;
      end

      if (cmd.land) begin
        frame_pos <= rd_data;
        t_palette <= 1'b1;
        if (t_count == 5'd0) t_first <= rd_data;
        t_count <= t_count + 5'd1;
        if (cmd.seek_kind != SK_REW) begin
          mode_reg <= TM_PLAY; speed_reg <= 4'd1;
          t_act <= AUD_RESTART; t_at <= rd_data; audio_live <= 1'b1;
        end
      end

      if (cmd.move) begin
        if (mode_reg == TM_REWIND) begin
          if (rewind_count == 8'd1) begin
            rewind_count <= rewind_period;
            if (frame_pos == '0) begin
              mode_reg <= TM_PLAY;
              t_act <= AUD_RESTART; t_at <= '0; audio_live <= 1'b1;
            end
          end else begin
            rewind_count <= rewind_count - 8'd1;
          end
        end else if (mode_reg != TM_PAUSE) begin
          steps <= speed_reg;
        end
      end

      if (cmd.step) begin
        if (t_count == 5'd0) t_first <= frame_pos;
        t_count <= t_count + 5'd1;
        if (pos_inc >= fc || pos_inc == '0) begin
          frame_pos <= '0;
          t_palette <= 1'b1;
          steps <= 4'd0;
          if (mode_reg == TM_PLAY) begin
            t_act <= AUD_RESTART; t_at <= '0; audio_live <= 1'b1;
          end
        end else begin
          frame_pos <= pos_inc;
          steps <= steps - 4'd1;
        end
      end

      if (cmd.finish) begin
        transport_mode <= mode_reg;
        speed_now      <= speed_reg;
        position       <= 24'(frame_pos);
        shown_first    <= 24'(t_first);
        shown_count    <= t_count;
        palette_reload <= t_palette;
        audio_action   <= t_act;
        audio_frame    <= 24'(t_at);
        overlay_on     <= b_tick && overlay_count != 10'd0;
        if (b_tick && overlay_count != 10'd0) overlay_count <= overlay_count - 10'd1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_win: assert property (@(posedge clk) disable iff (rst)
    cmd.cmp |-> lo < hi) else $error("search window empty");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> t_count < 5'd16) else $error("too many frames shown");
  a_one: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.buttons, cmd.cmp, cmd.land, cmd.step, cmd.finish}))
    else $error("overlapping datapath commands");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/playback_transport_controller.sv =====
// top level of the playback transport controller
// usage:
//   one input channel (valid/stall) carries load beats (mode 0) that write the
//   sorted keyframe table and tick beats (mode 1), one per video frame, with
//   the held pad buttons and start
//   one output channel (valid/stall) returns exactly one result beat per input
//   the config port writes registers by index; the user writes them only while
//   the block is idle, the block itself does not enforce it
// sequence:
//   a load beat writes its table entry and latches its result
//   a tick beat applies the buttons, runs any C and D seeks, then counts down
//   rewind or steps speed_now frames in play or forward; each seek sets up the
//   window, halves it per step of the keyframe search (log2 of the keyframe
//   count) and lands; a rewind jump runs the same search and skips frame stepping
//   the longest tick beat is a C and D seek together over a full table
//   one beat is worked at a time; input stall stays high from the time a beat
//   is taken until its result is taken
// reset:
//   synchronous rst returns registers to defaults, play mode at frame one;
//   the keyframe table is not cleared
// a stalled result holds its fields until taken
`default_nettype none
module playback_transport_controller
  import ptc_pkg::*;
#(
  parameter int KEY_DEPTH  = KeyDepthDefault,
  parameter int FRAME_BITS = FrameBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        mode,
  input  wire logic [9:0]  key_slot,
  input  wire logic [23:0] key_value,
  input  wire logic [7:0]  pad_bits,
  input  wire logic        start_held,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       transport_mode,
  output logic [3:0]       speed_now,
  output logic [23:0]      position,
  output logic [23:0]      shown_first,
  output logic [4:0]       shown_count,
  output logic             palette_reload,
  output logic [1:0]       audio_action,
  output logic [23:0]      audio_frame,
  output logic             overlay_on,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  ptc_cmd_t cmd;
  ptc_sts_t sts;

  // sequencer
  ptc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  // datapath with keyframe memory
  ptc_dp #(.KEY_DEPTH(KEY_DEPTH), .FRAME_BITS(FRAME_BITS)) u_dp (
    .clk, .rst, .cmd, .sts, .cfg_we, .cfg_index, .cfg_data,
    .mode, .key_slot, .key_value, .pad_bits, .start_held,
    .transport_mode, .speed_now, .position, .shown_first, .shown_count,
    .palette_reload, .audio_action, .audio_frame, .overlay_on
  );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the playback transport controller
`timescale 1ns / 100ps
module testbench;
  import ptc_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int KEYS = 1024;

  // one input beat as the driver offers it
  typedef struct {
    logic        mode;
    logic [9:0]  slot;
    logic [23:0] value;
    logic [7:0]  pad;
    logic        start;
  } beat_t;

  // one result beat
  typedef struct packed {
    tmode_t      tmode;
    logic [3:0]  speed;
    logic [23:0] pos;
    logic [23:0] first;
    logic [4:0]  count;
    logic        palette;
    audio_t      act;
    logic [23:0] at;
    logic        overlay;
  } frame_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = 1'b0;
  logic [9:0] key_slot = '0;
  logic [23:0] key_value = '0;
  logic [7:0] pad_bits = '0;
  logic start_held = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] transport_mode;
  logic [3:0] speed_now;
  logic [23:0] position, shown_first, audio_frame;
  logic [4:0] shown_count;
  logic palette_reload, overlay_on;
  logic [1:0] audio_action;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  playback_transport_controller i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .key_slot(key_slot), .key_value(key_value),
    .pad_bits(pad_bits), .start_held(start_held),
    .out_valid(out_valid), .out_stall(out_stall),
    .transport_mode(transport_mode), .speed_now(speed_now), .position(position),
    .shown_first(shown_first), .shown_count(shown_count),
    .palette_reload(palette_reload), .audio_action(audio_action),
    .audio_frame(audio_frame), .overlay_on(overlay_on),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // transport model: registers, state and keyframe table
  // ---------------------------------------------------------------
  logic [23:0] frames_cfg;
  logic [10:0] keys_cfg;
  logic [15:0] seek_cfg;
  logic [7:0]  rew_period_cfg;
  logic [9:0]  hold_cfg;
  logic [3:0]  ladder_cfg [3];

  tmode_t      tp_mode;
  logic [1:0]  tp_level;
  logic [3:0]  tp_speed;
  logic [23:0] tp_pos;
  logic [7:0]  tp_rew_left;
  logic [9:0]  tp_overlay_left;
  logic [7:0]  tp_prev_pad;
  logic        tp_prev_start;
  logic        tp_audio_live;
  logic [23:0] keyframes [KEYS];

  function automatic void show_frame(inout frame_report_t r, input logic [23:0] f);
    if (r.count == 0) r.first = f;
    r.count = r.count + 1'b1;
  endfunction

  function automatic void audio_restart(inout frame_report_t r, input logic [23:0] f);
    r.act = AUD_RESTART;
    r.at = f;
    tp_audio_live = 1'b1;
  endfunction

  function automatic void audio_silence(inout frame_report_t r);
    // a halt with audio already silent issues nothing
    if (tp_audio_live) begin
      r.act = AUD_HALT;
      r.at = '0;
      tp_audio_live = 1'b0;
    end
  endfunction

  // last keyframe at or before f (entry 0 when all are later)
  function automatic logic [23:0] keyframe_at(input logic [23:0] f);
    int unsigned n, lo, hi, mid;
    n = keys_cfg;
    if (n == 0) n = 1;
    if (n > KEYS) n = KEYS;
    lo = 0;
    hi = n;
    while (lo + 1 < hi) begin
      mid = (lo + hi) >> 1;
      if (keyframes[mid] <= f) lo = mid;
      else hi = mid;
    end
    return keyframes[lo];
  endfunction

  // seek target clamped to the last frame, then snapped to a keyframe
  function automatic logic [23:0] seek_landing(inout frame_report_t r,
                                               input longint unsigned target,
                                               input int unsigned fc);
    logic [23:0] land;
    if (target >= fc) target = fc - 1;
    land = keyframe_at(target[23:0]);
    r.palette = 1'b1;
    show_frame(r, land);
    return land;
  endfunction

  function automatic frame_report_t transport_step(input beat_t b);
    frame_report_t r;
    logic [7:0] pressed;
    logic start_edge;
    int unsigned fc, steps;
    r = '0;
    if (!b.mode) begin
      keyframes[b.slot] = b.value;
    end else begin
      pressed = b.pad & ~tp_prev_pad;
      start_edge = b.start & ~tp_prev_start;
      fc = (frames_cfg == 0) ? 1 : frames_cfg;
      tp_prev_pad = b.pad;
      tp_prev_start = b.start;
      if (pressed != 0 || start_edge) tp_overlay_left = hold_cfg;
      if ((pressed & BtnA) != 0 || start_edge) begin
        tp_mode = (tp_mode == TM_PAUSE) ? TM_PLAY : TM_PAUSE;
        tp_speed = 1;
        if (tp_mode == TM_PAUSE) audio_silence(r);
        else audio_restart(r, tp_pos);
      end
      if ((pressed & BtnB) != 0) begin
        tp_mode = TM_PLAY;
        tp_speed = 1;
        audio_restart(r, tp_pos);
      end
      if ((pressed & BtnRight) != 0) begin
        if (tp_mode != TM_FORWARD) tp_level = 0;
        else if (tp_level < 2) tp_level = tp_level + 1'b1;
        tp_mode = TM_FORWARD;
        tp_speed = ladder_cfg[tp_level];
        audio_silence(r);
      end
      if ((pressed & BtnLeft) != 0) begin
        tp_mode = TM_REWIND;
        tp_speed = 1;
        tp_rew_left = rew_period_cfg;
        audio_silence(r);
      end
      if ((pressed & BtnC) != 0) begin
        tp_pos = seek_landing(r, (tp_pos > seek_cfg) ? tp_pos - seek_cfg : 0, fc);
        tp_mode = TM_PLAY;
        tp_speed = 1;
        audio_restart(r, tp_pos);
      end
      if ((pressed & BtnD) != 0) begin
        tp_pos = seek_landing(r, longint'(tp_pos) + seek_cfg, fc);
        tp_mode = TM_PLAY;
        tp_speed = 1;
        audio_restart(r, tp_pos);
      end
      if (tp_mode == TM_REWIND) begin
        // 8-bit countdown, so a zero period gives 256 ticks
        tp_rew_left = tp_rew_left - 1'b1;
        if (tp_rew_left == 0) begin
          tp_rew_left = rew_period_cfg;
          if (tp_pos == 0) begin
            tp_mode = TM_PLAY;
            audio_restart(r, '0);
          end else begin
            tp_pos = keyframe_at(tp_pos - 1'b1);
            r.palette = 1'b1;
            show_frame(r, tp_pos);
          end
        end
      end else if (tp_mode != TM_PAUSE) begin
        steps = tp_speed;
        while (steps > 0) begin
          steps--;
          show_frame(r, tp_pos);
          tp_pos = tp_pos + 1'b1;
          if (tp_pos >= fc || tp_pos == 0) begin
            tp_pos = '0;
            r.palette = 1'b1;
            if (tp_mode == TM_PLAY) audio_restart(r, '0);
            break;
          end
        end
      end
      if (tp_overlay_left != 0) begin
        tp_overlay_left = tp_overlay_left - 1'b1;
        r.overlay = 1'b1;
      end
    end
    r.tmode = tp_mode;
    r.speed = tp_speed;
    r.pos = tp_pos;
    return r;
  endfunction

  // ---------------------------------------------------------------
  // driver: beats leave the pending queue at falling edges
  // ---------------------------------------------------------------
  beat_t pending_beats [$];
  frame_report_t expected_reports [$];
  int unsigned beats_taken = 0, beats_seen = 0, sender_gap = 0;
  bit no_idle = 1'b0;
  int unsigned loads_sent = 0, ticks_sent = 0, reports_checked = 0, errors = 0;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      beat_t b;
      b.mode = mode;
      b.slot = key_slot;
      b.value = key_value;
      b.pad = pad_bits;
      b.start = start_held;
      expected_reports.push_back(transport_step(b));
      if (mode) ticks_sent++;
      else loads_sent++;
      beats_taken++;
    end
  end

  always @(negedge clk) begin
    // hold a beat that has not been taken yet
    if (!(rst || (in_valid && beats_taken == beats_seen))) begin
      if (in_valid) begin
        beats_seen = beats_taken;
        sender_gap = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (sender_gap > 0) begin
        sender_gap--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        beat_t b;
        b = pending_beats.pop_front();
        mode <= b.mode;
        key_slot <= b.slot;
        key_value <= b.value;
        pad_bits <= b.pad;
        start_held <= b.start;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // monitor: results checked at rising edges
  // ---------------------------------------------------------------
  int unsigned receiver_wait = 0;
  int unsigned long_hold_left = 0;
  bit long_hold_go = 1'b0, long_hold_started = 1'b0;

  // long receiver hold-off, counted here while the sender keeps offering
  always @(negedge clk) begin
    if (long_hold_go && !long_hold_started) begin
      long_hold_started = 1'b1;
      long_hold_left = 400;
    end else if (long_hold_left > 0) begin
      long_hold_left--;
    end
  end

  always @(negedge clk) begin
    if (long_hold_left > 0) begin
      out_stall <= 1'b1;
    end else if (receiver_wait > 0) begin
      receiver_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $display("%0t unexpected result beat, position %0d", $time, position);
        errors++;
      end else begin
        frame_report_t e;
        e = expected_reports.pop_front();
        check_field("transport_mode", e.tmode, transport_mode);
        check_field("speed_now", e.speed, speed_now);
        check_field("position", e.pos, position);
        check_field("shown_first", e.first, shown_first);
        check_field("shown_count", e.count, shown_count);
        check_field("palette_reload", e.palette, palette_reload);
        check_field("audio_action", e.act, audio_action);
        check_field("audio_frame", e.at, audio_frame);
        check_field("overlay_on", e.overlay, overlay_on);
        reports_checked++;
      end
      receiver_wait = no_idle ? 0 : $urandom_range(0, 4);
    end
  end

  // watchdog
  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------
  logic [7:0] gen_pad = '0;

  function automatic void queue_load(input int slot, input logic [23:0] v);
    beat_t b;
    b.mode = 1'b0;
    b.slot = slot;
    b.value = v;
    b.pad = $urandom;
    b.start = $urandom;
    pending_beats.push_back(b);
  endfunction

  function automatic void queue_tick(input logic [7:0] pad, input logic st);
    beat_t b;
    b.mode = 1'b1;
    b.slot = $urandom;
    b.value = $urandom;
    b.pad = pad;
    b.start = st;
    pending_beats.push_back(b);
  endfunction

  // press patterns: releases, single buttons, chords, held pads
  function automatic void queue_random_tick();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) gen_pad = '0;
    else if (pick < 70) gen_pad = 8'h1 << $urandom_range(0, 7);
    else if (pick < 85) gen_pad = $urandom;
    queue_tick(gen_pad, $urandom_range(0, 9) == 0);
  endfunction

  task automatic wait_idle();
    while (pending_beats.size() > 0 || in_valid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      CfgFrameCount: frames_cfg = v;
      CfgKeyCount:   keys_cfg = v[10:0];
      CfgSeekFrames: seek_cfg = v[15:0];
      CfgRewPeriod:  rew_period_cfg = v[7:0];
      CfgOverlay:    hold_cfg = v[9:0];
      CfgSpeedLow:   ladder_cfg[0] = v[3:0];
      CfgSpeedMid:   ladder_cfg[1] = v[3:0];
      default:       ladder_cfg[2] = v[3:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [23:0] fc, input logic [10:0] kc,
                           input logic [15:0] sk, input logic [7:0] rp,
                           input logic [9:0] oh, input logic [3:0] s0,
                           input logic [3:0] s1, input logic [3:0] s2);
    write_reg(CfgFrameCount, fc);
    write_reg(CfgKeyCount, kc);
    write_reg(CfgSeekFrames, sk);
    write_reg(CfgRewPeriod, rp);
    write_reg(CfgOverlay, oh);
    write_reg(CfgSpeedLow, s0);
    write_reg(CfgSpeedMid, s1);
    write_reg(CfgSpeedHigh, s2);
  endtask

  initial begin
    logic [23:0] kv;
    int unsigned fc;
    // reset defaults of the registers and transport state
    frames_cfg = 2;
    keys_cfg = 1;
    seek_cfg = 600;
    rew_period_cfg = 6;
    hold_cfg = 180;
    ladder_cfg[0] = 2;
    ladder_cfg[1] = 5;
    ladder_cfg[2] = 10;
    tp_mode = TM_PLAY;
    tp_level = 0;
    tp_speed = 1;
    tp_pos = 1;
    tp_rew_left = 6;
    tp_overlay_left = 180;
    tp_prev_pad = '0;
    tp_prev_start = 1'b0;
    tp_audio_live = 1'b1;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill the whole keyframe table in ascending order before any lookup
    kv = '0;
    for (int i = 0; i < KEYS; i++) begin
      queue_load(i, kv);
      kv = kv + $urandom_range(1, 16000);
    end
    wait_idle();

    // directed: short movie with close keyframes in the first sixteen slots
    write_all(5000, 16, 600, 6, 180, 2, 5, 10);
    for (int i = 0; i < 16; i++) queue_load(i, i * 300);
    queue_tick(BtnA, 1'b0);             // pause
    queue_tick('0, 1'b1);               // start resumes play
    queue_tick('0, 1'b0);
    queue_tick(BtnRight, 1'b0);         // forward, first speed
    queue_tick('0, 1'b0);
    queue_tick(BtnRight, 1'b0);         // second speed
    queue_tick('0, 1'b0);
    queue_tick(BtnRight, 1'b0);         // third speed
    queue_tick('0, 1'b0);
    queue_tick(BtnRight, 1'b0);         // ladder saturates
    queue_tick(BtnLeft, 1'b0);          // rewind
    repeat (7) queue_tick(BtnLeft, 1'b0);
    queue_tick(BtnD, 1'b0);             // seek forward
    queue_tick(BtnC, 1'b0);             // seek back
    queue_tick(8'hFF, 1'b1);            // everything at once
    queue_tick('0, 1'b0);
    queue_load(1023, 24'hFFFFFF);
    wait_idle();

    // random phases; the first ones pin the register extremes
    for (int p = 0; p < 12; p++) begin
      no_idle = (p % 4 == 2);
      case (p)
        0: write_all(0, 0, 0, 1, 0, 0, 0, 0);
        1: write_all(24'hFFFFFF, 2047, 16'hFFFF, 8'hFF, 10'h3FF, 15, 15, 15);
        2: write_all(2, 1, 1, 0, 1, 1, 2, 3);
        default: begin
          fc = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 24'hFFFFFF)
                                           : $urandom_range(2, 3000);
          write_all(fc, $urandom_range(1, KEYS), $urandom_range(0, 4000),
                    $urandom_range(1, 20), $urandom_range(0, 1023),
                    $urandom_range(1, 15), $urandom_range(1, 15), $urandom_range(1, 15));
        end
      endcase
      // small movies get a dense ascending head of the table
      if (p >= 3 && frames_cfg <= 3000) begin
        kv = '0;
        for (int i = 0; i < 16; i++) begin
          queue_load(i, kv);
          kv = kv + $urandom_range(0, frames_cfg / 16);
        end
      end
      for (int i = 0; i < 70; i++) begin
        if ($urandom_range(0, 9) == 0) queue_load($urandom_range(0, KEYS - 1), $urandom);
        else queue_random_tick();
      end
      // hold the results back long enough for the input to back up
      if (p == 3) long_hold_go = 1'b1;
      wait_idle();
    end

    repeat (200) @(posedge clk);
    $display("covered %0d table loads and %0d frame ticks over 14 register settings,",
             loads_sent, ticks_sent);
    $display("%0d result beats checked, %0d mismatches", reports_checked, errors);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_ctrl.sv
hw/rtl/ptc_dp.sv
hw/rtl/playback_transport_controller.sv
sim/testbench.sv
